FILE: rtl/msixl_pkg.sv
// Shared types, codes and sizes for the MSI-X vector notification ledger.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package msixl_pkg;

   localparam int VEC_COUNT = 32;
   localparam int VEC_W     = 5;
   localparam int VEC_IN_W  = 8;
   localparam int STAMP_W   = 64;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_SET_MASK = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ARM      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_NOTIFY   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RETRY    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOST     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SNAPSHOT = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK            = 4'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID       = 4'd1;
   localparam logic [STATUS_W-1:0] ST_STALE         = 4'd2;
   localparam logic [STATUS_W-1:0] ST_LOST          = 4'd3;
   localparam logic [STATUS_W-1:0] ST_MASKED        = 4'd4;
   localparam logic [STATUS_W-1:0] ST_DISARMED      = 4'd5;
   localparam logic [STATUS_W-1:0] ST_INJECT_FAILED = 4'd6;
   localparam logic [STATUS_W-1:0] ST_NONE_PENDING  = 4'd7;
   localparam logic [STATUS_W-1:0] ST_ALREADY_ARMED = 4'd8;

   localparam logic [CSR_IDX_W-1:0] REG_GENERATION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_COMPLETION = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [STAMP_W-1:0]  generation;
      logic [VEC_IN_W-1:0] vector;
      logic [STAMP_W-1:0]  timeline;
      logic                mask_value;
      logic                sink_accepts;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                interrupt_fired;
      logic [VEC_W-1:0]    fired_vector;
      logic                vec_masked;
      logic                vec_pending;
      logic                vec_armed;
      logic [STAMP_W-1:0]  pending_time;
      logic [STAMP_W-1:0]  last_delivered_time;
      logic [STAMP_W-1:0]  delivery_total;
      logic [STAMP_W-1:0]  armed_time;
   } rsp_type;

   // Wide per-vector fields kept in the table memory.
   typedef struct packed {
      logic [STAMP_W-1:0] pstamp;
      logic [STAMP_W-1:0] dstamp;
      logic [STAMP_W-1:0] count;
      logic [STAMP_W-1:0] astamp;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

FILE: rtl/msixl_if.sv
// Request and response channel interfaces of the ledger.
// Depends on msixl_pkg for field widths.
`timescale 1ns / 1ps

interface msixl_req_if import msixl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [STAMP_W-1:0]  generation;
   logic [VEC_IN_W-1:0] vector;
   logic [STAMP_W-1:0]  timeline;
   logic                mask_value;
   logic                sink_accepts;

   modport source (output valid, command, generation, vector, timeline, mask_value,
                   sink_accepts, input ready);
   modport sink (input valid, command, generation, vector, timeline, mask_value,
                 sink_accepts, output ready);
endinterface

interface msixl_rsp_if import msixl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                interrupt_fired;
   logic [VEC_W-1:0]    fired_vector;
   logic                vec_masked;
   logic                vec_pending;
   logic                vec_armed;
   logic [STAMP_W-1:0]  pending_time;
   logic [STAMP_W-1:0]  last_delivered_time;
   logic [STAMP_W-1:0]  delivery_total;
   logic [STAMP_W-1:0]  armed_time;

   modport source (output valid, status, interrupt_fired, fired_vector, vec_masked,
                   vec_pending, vec_armed, pending_time, last_delivered_time,
                   delivery_total, armed_time, input ready);
   modport sink (input valid, status, interrupt_fired, fired_vector, vec_masked,
                 vec_pending, vec_armed, pending_time, last_delivered_time,
                 delivery_total, armed_time, output ready);
endinterface

FILE: rtl/msixl_ctrl.sv
// Controller of the ledger: sequences capture and commit of one item.
// Depends on msixl_pkg for the command struct.
`timescale 1ns / 1ps

module msixl_ctrl import msixl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_EXEC = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;

   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.commit  = (state_ff == S_EXEC) && (!out_valid_ff || rsp_ready);
      state_in    = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

FILE: rtl/msixl_datapath.sv
// Datapath of the ledger: vector table, configuration registers, command
// evaluation and the result register. Depends on msixl_pkg.
`timescale 1ns / 1ps

module msixl_datapath import msixl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   input  req_type              req,
   output rsp_type              rsp,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STAMP_W-1:0]   csr_wdata
);

   // Configuration and device state.
   logic [STAMP_W-1:0] active_gen_ff;
   logic [VEC_W-1:0]   compl_vec_ff;
   logic               online_ff;

   // Per-vector flags in flops; wide fields in the table memory with a valid bit.
   logic [VEC_COUNT-1:0] mask_ff, pend_ff, armed_ff, valid_ff;
   entry_type            table_mem [VEC_COUNT];
   entry_type            rd_ff;

   // Captured item.
   logic [CMD_W-1:0]   cmd_ff;
   logic [STAMP_W-1:0] tl_ff;
   logic [VEC_W-1:0]   addr_ff, addr_in;
   logic               in_range_ff, in_range_in;
   logic               gen_zero_ff, gen_match_ff, tl_zero_ff, mval_ff, acc_ff;

   rsp_type rsp_ff, rsp_in;

   // Evaluation signals.
   entry_type          ent, ne;
   logic               cur_mask, cur_pend, cur_arm;
   logic               new_mask, new_pend, new_arm;
   logic [STATUS_W-1:0] st, gate_st;
   logic               do_try, fire, online_clr, addr_is_cv;
   logic               tl_le_d, tl_le_a, tl_lt_a, tl_gt_p, tl_gt_d, p_gt_d;
   logic [STAMP_W-1:0] pd_max, notify_d;

   always_comb begin
      if (req.command == CMD_ARM) begin
         addr_in     = compl_vec_ff;
         in_range_in = (9'(compl_vec_ff) < 9'(VEC_COUNT));
      end else begin
         addr_in     = req.vector[VEC_W-1:0];
         in_range_in = (9'(req.vector) < 9'(VEC_COUNT));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff       <= req.command;
         tl_ff        <= req.timeline;
         addr_ff      <= addr_in;
         in_range_ff  <= in_range_in;
         gen_zero_ff  <= (req.generation == '0);
         gen_match_ff <= (req.generation == active_gen_ff);
         tl_zero_ff   <= (req.timeline == '0);
         mval_ff      <= req.mask_value;
         acc_ff       <= req.sink_accepts;
         rd_ff        <= table_mem[addr_in];
      end
      if (cmd.commit && in_range_ff) begin
         table_mem[addr_ff] <= ne;
      end
   end

   always_comb begin
      ent      = valid_ff[addr_ff] ? rd_ff : '0;
      cur_mask = mask_ff[addr_ff];
      cur_pend = pend_ff[addr_ff];
      cur_arm  = armed_ff[addr_ff];
      addr_is_cv = (addr_ff == compl_vec_ff);

      // All wide compares run side by side; selection follows.
      tl_le_d = (tl_ff <= ent.dstamp);
      tl_le_a = (tl_ff <= ent.astamp);
      tl_lt_a = (tl_ff < ent.astamp);
      tl_gt_p = (tl_ff > ent.pstamp);
      tl_gt_d = (tl_ff > ent.dstamp);
      p_gt_d  = (ent.pstamp > ent.dstamp);
      pd_max  = p_gt_d ? ent.pstamp : ent.dstamp;
      notify_d = tl_gt_p ? (tl_gt_d ? tl_ff : ent.dstamp) : pd_max;

      if (!in_range_ff || gen_zero_ff) begin
         gate_st = ST_INVALID;
      end else if (!gen_match_ff) begin
         gate_st = ST_STALE;
      end else if (!online_ff) begin
         gate_st = ST_LOST;
      end else begin
         gate_st = ST_OK;
      end

      ne         = ent;
      new_mask   = cur_mask;
      new_pend   = cur_pend;
      new_arm    = cur_arm;
      do_try     = 1'b0;
      fire       = 1'b0;
      online_clr = 1'b0;
      st         = gate_st;

      case (cmd_ff)
         CMD_SET_MASK: begin
            if (st == ST_OK) begin
               new_mask = mval_ff;
               do_try   = !mval_ff && cur_pend;
            end
         end
         CMD_ARM: begin
            if (st == ST_OK && tl_zero_ff) st = ST_INVALID;
            if (st == ST_OK) begin
               if (tl_le_d || (cur_arm && tl_le_a)) begin
                  st = ST_ALREADY_ARMED;
               end else begin
                  new_arm   = 1'b1;
                  ne.astamp = tl_ff;
               end
            end
         end
         CMD_NOTIFY: begin
            if (st == ST_OK && tl_zero_ff) st = ST_INVALID;
            if (st == ST_OK) begin
               if (addr_is_cv && (!cur_arm || tl_lt_a)) begin
                  st = ST_DISARMED;
               end else begin
                  new_pend  = 1'b1;
                  ne.pstamp = tl_gt_p ? tl_ff : ent.pstamp;
                  if (cur_mask) st = ST_MASKED;
                  else do_try = 1'b1;
               end
            end
         end
         CMD_RETRY: begin
            do_try = (st == ST_OK);
         end
         CMD_LOST: begin
            if (gen_zero_ff) begin
               st = ST_INVALID;
            end else if (!gen_match_ff) begin
               st = ST_STALE;
            end else begin
               st         = ST_OK;
               online_clr = 1'b1;
            end
         end
         CMD_SNAPSHOT: begin
         end
         default: st = ST_INVALID;
      endcase

      // Delivery attempt shared by set mask, notify and retry.
      if (do_try) begin
         if (!new_pend) begin
            st = ST_NONE_PENDING;
         end else if (new_mask) begin
            st = ST_MASKED;
         end else if (!acc_ff) begin
            st = ST_INJECT_FAILED;
         end else begin
            st        = ST_OK;
            fire      = 1'b1;
            ne.dstamp = (cmd_ff == CMD_NOTIFY) ? notify_d : pd_max;
            ne.count  = (&ent.count) ? ent.count : ent.count + STAMP_W'(1);
            new_pend  = 1'b0;
            ne.pstamp = '0;
            if (addr_is_cv) begin
               new_arm   = 1'b0;
               ne.astamp = '0;
            end
         end
      end

      rsp_in.status          = st;
      rsp_in.interrupt_fired = fire;
      rsp_in.fired_vector    = fire ? addr_ff : '0;
      if (in_range_ff) begin
         rsp_in.vec_masked          = new_mask;
         rsp_in.vec_pending         = new_pend;
         rsp_in.vec_armed           = new_arm;
         rsp_in.pending_time        = ne.pstamp;
         rsp_in.last_delivered_time = ne.dstamp;
         rsp_in.delivery_total      = ne.count;
         rsp_in.armed_time          = ne.astamp;
      end else begin
         rsp_in.vec_masked          = 1'b0;
         rsp_in.vec_pending         = 1'b0;
         rsp_in.vec_armed           = 1'b0;
         rsp_in.pending_time        = '0;
         rsp_in.last_delivered_time = '0;
         rsp_in.delivery_total      = '0;
         rsp_in.armed_time          = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   // Control state: configuration, online flag, per-vector flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_gen_ff <= STAMP_W'(1);
         compl_vec_ff  <= '0;
         online_ff     <= 1'b1;
         mask_ff       <= '0;
         pend_ff       <= '0;
         armed_ff      <= '0;
         valid_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               REG_GENERATION: begin
                  if (csr_wdata != '0) begin
                     active_gen_ff <= csr_wdata;
                     online_ff     <= 1'b1;
                     mask_ff       <= '0;
                     pend_ff       <= '0;
                     armed_ff      <= '0;
                     valid_ff      <= '0;
                  end
               end
               REG_COMPLETION: begin
                  compl_vec_ff <= csr_wdata[VEC_W-1:0];
               end
            endcase
         end
         if (cmd.commit) begin
            if (online_clr) online_ff <= 1'b0;
            if (in_range_ff) begin
               mask_ff[addr_ff]  <= new_mask;
               pend_ff[addr_ff]  <= new_pend;
               armed_ff[addr_ff] <= new_arm;
               valid_ff[addr_ff] <= 1'b1;
            end
         end
      end
   end

   assign rsp = rsp_ff;

endmodule

FILE: rtl/msix_vector_notification_ledger_core.sv
// An item is captured into the datapath when accepted; its result is committed
// to the output register from the execute state, and the commit waits while a
// previous result is still waiting to be taken. A new item is accepted only after
// that commit: the table read registered at accept is updated and written back.
// Reset (synchronous, active high) sets generation 1, completion vector 0,
// online, and an empty table; no clearing pass is needed.
`timescale 1ns / 1ps

module msix_vector_notification_ledger_core import msixl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   msixl_req_if.sink            req_if,
   msixl_rsp_if.source          rsp_if,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STAMP_W-1:0]   csr_wdata
);

   // The controller decides when an item is captured into the datapath and
   // when its evaluated result is committed into the output register. A
   // commit happens only when the output register is empty or being drained.
   // While a result waits, the next item is still accepted; only its commit
   // waits, which in turn holds off the item after it.
   ctrl_cmd_type ctrl_cmd;
   req_type      req_payload;
   rsp_type      rsp_payload;

   // Gather the request fields into one bundle for the datapath.
   assign req_payload.command      = req_if.command;
   assign req_payload.generation   = req_if.generation;
   assign req_payload.vector       = req_if.vector;
   assign req_payload.timeline     = req_if.timeline;
   assign req_payload.mask_value   = req_if.mask_value;
   assign req_payload.sink_accepts = req_if.sink_accepts;

   msixl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (ctrl_cmd)
   );

   // The datapath holds the vector table. Flags live in flip-flops; the wide
   // stamps and counts live in a memory whose entries carry a valid bit, so a
   // generation write empties the whole table by clearing the flags and valid bits.
   msixl_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (ctrl_cmd),
      .req          (req_payload),
      .rsp          (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Spread the result bundle onto the response channel.
   assign rsp_if.status              = rsp_payload.status;
   assign rsp_if.interrupt_fired     = rsp_payload.interrupt_fired;
   assign rsp_if.fired_vector        = rsp_payload.fired_vector;
   assign rsp_if.vec_masked          = rsp_payload.vec_masked;
   assign rsp_if.vec_pending         = rsp_payload.vec_pending;
   assign rsp_if.vec_armed           = rsp_payload.vec_armed;
   assign rsp_if.pending_time        = rsp_payload.pending_time;
   assign rsp_if.last_delivered_time = rsp_payload.last_delivered_time;
   assign rsp_if.delivery_total      = rsp_payload.delivery_total;
   assign rsp_if.armed_time          = rsp_payload.armed_time;

`ifndef NO_ASSERTIONS
   // One item at a time: in the cycle after an accept the block is not ready.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request accepted on consecutive cycles");

   // An injection is only ever reported with a successful status.
   a_fire_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.interrupt_fired |-> rsp_if.status == ST_OK)
      else $error("interrupt fired with a failing status");

   // Without an injection the fired vector reads as zero.
   a_no_fire_zero_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.interrupt_fired |-> rsp_if.fired_vector == '0)
      else $error("fired vector set without an injection");

   // A delivered vector is left not pending.
   a_fire_clears_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.interrupt_fired |-> !rsp_if.vec_pending)
      else $error("vector still pending after delivery");
`endif

endmodule

FILE: tb/msix_vector_notification_ledger_core_tb.sv
// Self-checking testbench for the MSI-X vector notification ledger core.
// Depends on msixl_pkg and the msixl_req_if / msixl_rsp_if channel interfaces in rtl.
`timescale 1ns / 1ps

module msix_vector_notification_ledger_core_tb;
   import msixl_pkg::*;

   // Command codes the block does not define; they must be refused as invalid.
   localparam logic [CMD_W-1:0]   CMD_RSVD_LO = 3'd6;
   localparam logic [CMD_W-1:0]   CMD_RSVD_HI = 3'd7;
   localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
   localparam int PHASE_ITEMS = 260;
   localparam int PHASES      = 5;

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [STAMP_W-1:0]   csr_wdata;

   msixl_req_if req_ch ();
   msixl_rsp_if rsp_ch ();

   msix_vector_notification_ledger_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_ch),
      .rsp_if       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   // Idle and stall rates, in percent, for the current phase.
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // Fixed-expectation tag that travels with the item on the request channel.
   bit      row_fixed;
   rsp_type row_want;

   int error_count  = 0;
   int result_count = 0;

   // Outcomes of accepted items, oldest first, waiting for their result.
   rsp_type outcome_q[$];

   // ------------------------------------------------------------------
   // Ledger predictor: its own copy of the configuration and vector table.
   // ------------------------------------------------------------------
   logic [STAMP_W-1:0] cur_gen;
   logic [VEC_W-1:0]   comp_vec;
   bit                 online;
   bit                 vec_mask [VEC_COUNT];
   bit                 vec_pend [VEC_COUNT];
   bit                 vec_arm  [VEC_COUNT];
   logic [STAMP_W-1:0] pend_stamp [VEC_COUNT];
   logic [STAMP_W-1:0] dlv_stamp  [VEC_COUNT];
   logic [STAMP_W-1:0] dlv_count  [VEC_COUNT];
   logic [STAMP_W-1:0] arm_stamp  [VEC_COUNT];
   bit                 fired_now;
   logic [VEC_W-1:0]   fired_idx;

   // Random timeline that creeps upward so that stamps compare in both directions.
   logic [STAMP_W-1:0] tl_base;

   function automatic void clear_table();
      for (int i = 0; i < VEC_COUNT; i++) begin
         vec_mask[i]   = 1'b0;
         vec_pend[i]   = 1'b0;
         vec_arm[i]    = 1'b0;
         pend_stamp[i] = '0;
         dlv_stamp[i]  = '0;
         dlv_count[i]  = '0;
         arm_stamp[i]  = '0;
      end
   endfunction

   function automatic void ledger_reset();
      cur_gen  = 64'd1;
      comp_vec = '0;
      online   = 1'b1;
      clear_table();
   endfunction

   // A generation write of zero is dropped; any other value starts a new table.
   function automatic void csr_update(logic [CSR_IDX_W-1:0] idx, logic [STAMP_W-1:0] data);
      if (idx == REG_GENERATION) begin
         if (data != '0) begin
            cur_gen = data;
            online  = 1'b1;
            clear_table();
         end
      end else begin
         comp_vec = data[VEC_W-1:0];
      end
   endfunction

   function automatic logic [STATUS_W-1:0] access_check(logic [STAMP_W-1:0] gen,
                                                        logic [VEC_IN_W-1:0] v);
      if (v >= VEC_COUNT || gen == '0)
         return ST_INVALID;
      if (gen != cur_gen)
         return ST_STALE;
      return online ? ST_OK : ST_LOST;
   endfunction

   // Injects a pending, unmasked vector when the sink takes it.
   function automatic logic [STATUS_W-1:0] deliver(logic [VEC_W-1:0] v, logic accepts);
      if (!vec_pend[v])
         return ST_NONE_PENDING;
      if (vec_mask[v])
         return ST_MASKED;
      if (!accepts)
         return ST_INJECT_FAILED;
      fired_now = 1'b1;
      fired_idx = v;
      if (pend_stamp[v] > dlv_stamp[v])
         dlv_stamp[v] = pend_stamp[v];
      if (dlv_count[v] != STAMP_MAX)
         dlv_count[v] = dlv_count[v] + 64'd1;
      vec_pend[v]   = 1'b0;
      pend_stamp[v] = '0;
      if (v == comp_vec) begin
         vec_arm[v]   = 1'b0;
         arm_stamp[v] = '0;
      end
      return ST_OK;
   endfunction

   // Applies one command to the table and returns the result it must produce.
   function automatic rsp_type apply_command(req_type it);
      rsp_type             r;
      logic [STATUS_W-1:0] st;
      logic [VEC_IN_W-1:0] addr;
      logic [VEC_W-1:0]    v;
      r         = '0;
      fired_now = 1'b0;
      fired_idx = '0;
      addr      = (it.command == CMD_ARM) ? VEC_IN_W'(comp_vec) : it.vector;
      v         = it.vector[VEC_W-1:0];
      case (it.command)
         CMD_SET_MASK: begin
            st = access_check(it.generation, it.vector);
            if (st == ST_OK) begin
               vec_mask[v] = it.mask_value;
               if (!it.mask_value && vec_pend[v])
                  st = deliver(v, it.sink_accepts);
            end
         end
         CMD_ARM: begin
            st = access_check(it.generation, addr);
            if (st == ST_OK && it.timeline == '0)
               st = ST_INVALID;
            if (st == ST_OK) begin
               if (it.timeline <= dlv_stamp[comp_vec] ||
                   (vec_arm[comp_vec] && it.timeline <= arm_stamp[comp_vec])) begin
                  st = ST_ALREADY_ARMED;
               end else begin
                  vec_arm[comp_vec]   = 1'b1;
                  arm_stamp[comp_vec] = it.timeline;
               end
            end
         end
         CMD_NOTIFY: begin
            st = access_check(it.generation, it.vector);
            if (st == ST_OK && it.timeline == '0)
               st = ST_INVALID;
            if (st == ST_OK) begin
               // The completion vector only takes a notify at or after its arm stamp.
               if (v == comp_vec && (!vec_arm[v] || it.timeline < arm_stamp[v])) begin
                  st = ST_DISARMED;
               end else begin
                  vec_pend[v] = 1'b1;
                  if (it.timeline > pend_stamp[v])
                     pend_stamp[v] = it.timeline;
                  st = vec_mask[v] ? ST_MASKED : deliver(v, it.sink_accepts);
               end
            end
         end
         CMD_RETRY: begin
            st = access_check(it.generation, it.vector);
            if (st == ST_OK)
               st = deliver(v, it.sink_accepts);
         end
         CMD_LOST: begin
            // Only the generation is checked; the vector and online flag do not matter.
            if (it.generation == '0) begin
               st = ST_INVALID;
            end else if (it.generation != cur_gen) begin
               st = ST_STALE;
            end else begin
               online = 1'b0;
               st     = ST_OK;
            end
         end
         CMD_SNAPSHOT: st = access_check(it.generation, it.vector);
         default:      st = ST_INVALID;
      endcase
      r.status          = st;
      r.interrupt_fired = fired_now;
      r.fired_vector    = fired_idx;
      // Out-of-range vectors report an all-zero entry.
      if (addr < VEC_COUNT) begin
         r.vec_masked          = vec_mask[addr[VEC_W-1:0]];
         r.vec_pending         = vec_pend[addr[VEC_W-1:0]];
         r.vec_armed           = vec_arm[addr[VEC_W-1:0]];
         r.pending_time        = pend_stamp[addr[VEC_W-1:0]];
         r.last_delivered_time = dlv_stamp[addr[VEC_W-1:0]];
         r.delivery_total      = dlv_count[addr[VEC_W-1:0]];
         r.armed_time          = arm_stamp[addr[VEC_W-1:0]];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_error(string msg);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_error($sformatf("result %0d field %s: got %0h, expected %0h",
                                result_count, name, got, want));
   endtask

   // Results are checked before new items are recorded, so that a result and an
   // acceptance at the same edge never pair with each other.
   always @(posedge clock) begin : observe
      rsp_type got;
      rsp_type want;
      req_type acc;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status              = rsp_ch.status;
            got.interrupt_fired     = rsp_ch.interrupt_fired;
            got.fired_vector        = rsp_ch.fired_vector;
            got.vec_masked          = rsp_ch.vec_masked;
            got.vec_pending         = rsp_ch.vec_pending;
            got.vec_armed           = rsp_ch.vec_armed;
            got.pending_time        = rsp_ch.pending_time;
            got.last_delivered_time = rsp_ch.last_delivered_time;
            got.delivery_total      = rsp_ch.delivery_total;
            got.armed_time          = rsp_ch.armed_time;
            if (outcome_q.size() == 0) begin
               report_error("result arrived with no item outstanding");
            end else begin
               want = outcome_q.pop_front();
               check_field("status", 64'(got.status), 64'(want.status));
               check_field("interrupt_fired", 64'(got.interrupt_fired),
                           64'(want.interrupt_fired));
               check_field("fired_vector", 64'(got.fired_vector), 64'(want.fired_vector));
               check_field("vec_masked", 64'(got.vec_masked), 64'(want.vec_masked));
               check_field("vec_pending", 64'(got.vec_pending), 64'(want.vec_pending));
               check_field("vec_armed", 64'(got.vec_armed), 64'(want.vec_armed));
               check_field("pending_time", got.pending_time, want.pending_time);
               check_field("last_delivered_time", got.last_delivered_time,
                           want.last_delivered_time);
               check_field("delivery_total", got.delivery_total, want.delivery_total);
               check_field("armed_time", got.armed_time, want.armed_time);
            end
            result_count++;
         end
         if (req_ch.valid && req_ch.ready) begin
            acc.command      = req_ch.command;
            acc.generation   = req_ch.generation;
            acc.vector       = req_ch.vector;
            acc.timeline     = req_ch.timeline;
            acc.mask_value   = req_ch.mask_value;
            acc.sink_accepts = req_ch.sink_accepts;
            // The predictor always steps so its table follows the block; a typed-in
            // expectation then takes the place of its answer.
            want = apply_command(acc);
            if (row_fixed)
               want = row_want;
            outcome_q.push_back(want);
         end
      end
   end

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------
   // The receiver stalls at random; it is driven from time zero on.
   initial begin
      forever begin
         rsp_ch.ready = ($urandom_range(99) >= stall_pct);
         @(negedge clock);
      end
   end

   // Presents one item, possibly after idle cycles, and returns at the falling
   // edge after it was taken, with valid still high.
   task automatic send_item(req_type it, bit fixed, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.command      = it.command;
      req_ch.generation   = it.generation;
      req_ch.vector       = it.vector;
      req_ch.timeline     = it.timeline;
      req_ch.mask_value   = it.mask_value;
      req_ch.sink_accepts = it.sink_accepts;
      row_fixed           = fixed;
      row_want            = want;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Waits until every outstanding result has been taken, plus a short pause.
   task automatic wait_quiet();
      while (outcome_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [STAMP_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(posedge clock);
      csr_update(idx, data);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   function automatic logic [STAMP_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic stim_row_type mk_row(logic [CMD_W-1:0] cmd, logic [STAMP_W-1:0] gen,
                                           logic [VEC_IN_W-1:0] vec, logic [STAMP_W-1:0] tl,
                                           int mval, int accepts, int fixed,
                                           logic [STATUS_W-1:0] st);
      stim_row_type row;
      row.item.command      = cmd;
      row.item.generation   = gen;
      row.item.vector       = vec;
      row.item.timeline     = tl;
      row.item.mask_value   = 1'(mval);
      row.item.sink_accepts = 1'(accepts);
      row.fixed             = 1'(fixed);
      row.want              = '0;
      row.want.status       = st;
      return row;
   endfunction

   // Random item, biased toward the live generation, a few hot vectors and the
   // completion vector, so that arm, notify and delivery sequences chain up.
   // Marking the device lost is held back to the tail of a batch.
   function automatic req_type random_item(bit lost_ok);
      req_type it;
      int      r;
      r = $urandom_range(99);
      if (lost_ok && r < 20) begin
         it.command = CMD_LOST;
      end else begin
         r = $urandom_range(99);
         if (r < 26)      it.command = CMD_NOTIFY;
         else if (r < 42) it.command = CMD_ARM;
         else if (r < 58) it.command = CMD_RETRY;
         else if (r < 76) it.command = CMD_SET_MASK;
         else if (r < 93) it.command = CMD_SNAPSHOT;
         else if (r < 95) it.command = $urandom_range(1) ? CMD_RSVD_HI : CMD_RSVD_LO;
         else             it.command = CMD_NOTIFY;
      end

      r = $urandom_range(99);
      if (r < 90)      it.generation = cur_gen;
      else if (r < 94) it.generation = '0;
      else if (r < 97) it.generation = rand64();
      else             it.generation = cur_gen ^ (64'd1 << $urandom_range(63));

      r = $urandom_range(99);
      if (r < 40)      it.vector = VEC_IN_W'(comp_vec);
      else if (r < 80) it.vector = VEC_IN_W'($urandom_range(7));
      else if (r < 94) it.vector = VEC_IN_W'($urandom_range(VEC_COUNT - 1));
      else             it.vector = VEC_IN_W'($urandom_range(255));

      tl_base = tl_base + 64'($urandom_range(2));
      r = $urandom_range(99);
      if (r < 85)      it.timeline = tl_base - 64'd3 + 64'($urandom_range(6));
      else if (r < 91) it.timeline = '0;
      else if (r < 96) it.timeline = 64'($urandom_range(1, 3));
      else if (r < 98) it.timeline = rand64();
      else             it.timeline = STAMP_MAX - 64'($urandom_range(3));

      it.mask_value   = 1'($urandom_range(1));
      it.sink_accepts = ($urandom_range(99) < 70);
      return it;
   endfunction

   task automatic run_random(int count, bit lost_tail);
      for (int i = 0; i < count; i++)
         send_item(random_item(lost_tail && i >= count - 12), 1'b0, '0);
      req_ch.valid = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type dir_table[$];
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_index           = REG_GENERATION;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_SNAPSHOT;
      req_ch.generation   = '0;
      req_ch.vector       = '0;
      req_ch.timeline     = '0;
      req_ch.mask_value   = 1'b0;
      req_ch.sink_accepts = 1'b0;
      row_fixed           = 1'b0;
      row_want            = '0;
      tl_base             = 64'd8;
      ledger_reset();

      // Directed part. The first rows run on the table as reset left it, so an
      // all-zero entry with the given status can be written down directly.
      dir_table.push_back(mk_row(CMD_SNAPSHOT, 64'd1, 8'd0, 64'd0, 0, 0, 1, ST_OK));
      dir_table.push_back(mk_row(CMD_SNAPSHOT, 64'd1, 8'd255, 64'd0, 0, 0, 1, ST_INVALID));
      dir_table.push_back(mk_row(CMD_SNAPSHOT, 64'd1, 8'd32, 64'd0, 0, 0, 1, ST_INVALID));
      dir_table.push_back(mk_row(CMD_NOTIFY, 64'd0, 8'd5, 64'd9, 0, 1, 1, ST_INVALID));
      dir_table.push_back(mk_row(CMD_NOTIFY, STAMP_MAX, 8'd5, 64'd9, 0, 1, 1, ST_STALE));
      dir_table.push_back(mk_row(CMD_NOTIFY, 64'd1, 8'd5, 64'd0, 0, 1, 1, ST_INVALID));
      dir_table.push_back(mk_row(CMD_RSVD_LO, 64'd1, 8'd3, 64'd4, 1, 1, 1, ST_INVALID));
      dir_table.push_back(mk_row(CMD_RSVD_HI, 64'd1, 8'd31, 64'd4, 1, 1, 1, ST_INVALID));
      dir_table.push_back(mk_row(CMD_RETRY, 64'd1, 8'd7, 64'd0, 0, 1, 1, ST_NONE_PENDING));
      dir_table.push_back(mk_row(CMD_ARM, 64'd1, 8'd9, 64'd0, 0, 0, 1, ST_INVALID));
      dir_table.push_back(mk_row(CMD_NOTIFY, 64'd1, 8'd0, 64'd5, 0, 1, 1, ST_DISARMED));
      dir_table.push_back(mk_row(CMD_LOST, 64'd0, 8'd200, 64'd0, 0, 0, 1, ST_INVALID));
      dir_table.push_back(mk_row(CMD_LOST, 64'd2, 8'd200, 64'd0, 0, 0, 1, ST_STALE));
      // From here the predictor supplies the expectation.
      dir_table.push_back(mk_row(CMD_ARM, 64'd1, 8'd0, 64'd10, 0, 0, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_ARM, 64'd1, 8'd0, 64'd10, 0, 0, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_NOTIFY, 64'd1, 8'd0, 64'd9, 0, 1, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_SET_MASK, 64'd1, 8'd0, 64'd0, 1, 1, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_NOTIFY, 64'd1, 8'd0, 64'd12, 0, 1, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_SET_MASK, 64'd1, 8'd0, 64'd0, 0, 0, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_RETRY, 64'd1, 8'd0, 64'd0, 0, 1, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_ARM, 64'd1, 8'd0, 64'd12, 0, 0, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_NOTIFY, 64'd1, 8'd31, STAMP_MAX, 0, 1, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_NOTIFY, 64'd1, 8'd17, 64'd3, 0, 0, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_NOTIFY, 64'd1, 8'd17, 64'd2, 0, 0, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_RETRY, 64'd1, 8'd17, 64'd0, 0, 1, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_LOST, 64'd1, 8'd4, 64'd0, 0, 0, 0, ST_OK));
      dir_table.push_back(mk_row(CMD_SNAPSHOT, 64'd1, 8'd4, 64'd0, 0, 0, 0, ST_OK));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i])
         send_item(dir_table[i].item, dir_table[i].fixed, dir_table[i].want);
      req_ch.valid = 1'b0;

      // Random part. Each phase writes a generation (starting a new table) and a completion vector,
      // and moves the completion vector again halfway, while arm flags stand.
      for (int p = 0; p < PHASES; p++) begin
         wait_quiet();
         case (p)
            0: begin
               csr_write(REG_GENERATION, rand64() | 64'd1);
               csr_write(REG_COMPLETION, {rand64()} | 64'd31);
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               csr_write(REG_GENERATION, STAMP_MAX);
               csr_write(REG_COMPLETION, {rand64()} & ~64'd31);
               send_idle_pct = 49;
               stall_pct     = 0;
            end
            2: begin
               // Rewriting the same generation brings the device back; zero is dropped.
               csr_write(REG_GENERATION, cur_gen);
               csr_write(REG_GENERATION, '0);
               csr_write(REG_COMPLETION, rand64());
               send_idle_pct = 0;
               stall_pct     = 49;
            end
            3: begin
               csr_write(REG_GENERATION, 64'd1);
               csr_write(REG_COMPLETION, rand64());
               send_idle_pct = 6;
               stall_pct     = 6;
            end
            default: begin
               csr_write(REG_GENERATION, rand64() | 64'h8000_0000_0000_0000);
               csr_write(REG_COMPLETION, rand64());
               send_idle_pct = 0;
               stall_pct     = 0;
            end
         endcase
         tl_base = 64'd8;
         run_random(PHASE_ITEMS / 2, 1'b0);
         wait_quiet();
         csr_write(REG_COMPLETION, rand64());
         run_random(PHASE_ITEMS - PHASE_ITEMS / 2, 1'b1);
      end

      wait_quiet();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Far beyond the slowest correct run of this stimulus.
   initial begin : watchdog
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
rtl/msixl_pkg.sv
rtl/msixl_if.sv
rtl/msixl_ctrl.sv
rtl/msixl_datapath.sv
rtl/msix_vector_notification_ledger_core.sv
tb/msix_vector_notification_ledger_core_tb.sv
